// File: sv/brb_pkg.sv
// Shared types and constants for the beacon range and bearing block.
// No dependencies; every other file in this folder refers to it by scoped name.
package brb_pkg;

    typedef logic [63:0]        t_u64;
    typedef logic signed [63:0] t_s64;

    // Default turn length in sensor ticks
    localparam int TICKS_PER_TURN = 1750;

    // Beacon width register
    localparam int                CFG_W              = 10;
    localparam logic [CFG_W-1:0]  BEACON_WIDTH_RESET = 10'd60;

    // Distance result, Q.8 millimetres
    localparam int                DIST_W    = 28;
    localparam int                DIST_FRAC = 8;
    localparam logic [DIST_W-1:0] DIST_MAX  = '1;

    // Fixed-point formats of the cotangent table
    localparam int   COT_FRAC   = 16;
    localparam int   ANGLE_FRAC = 30;
    localparam t_u64 PI_Q30     = 64'd3373259426;
    localparam t_u64 ONE_Q30    = 64'd1073741824;

endpackage

// File: sv/brb_tick_if.sv
// Input channel: one beat carries the rising-edge and falling-edge tick of a beacon.
// Depends on brb_pkg for the default turn length.
interface brb_tick_if #(
    parameter int TICKS_PER_TURN = brb_pkg::TICKS_PER_TURN
);
    localparam int TICK_W = $clog2(TICKS_PER_TURN);

    logic              valid;
    logic              ready;
    logic [TICK_W-1:0] rising_tick;
    logic [TICK_W-1:0] falling_tick;

    modport source (output valid, rising_tick, falling_tick, input ready);
    modport sink   (input valid, rising_tick, falling_tick, output ready);
endinterface

// File: sv/brb_range_if.sv
// Output channel: one beat carries width, bearing and distance of one beacon.
// Depends on brb_pkg for the default turn length and the distance format.
interface brb_range_if #(
    parameter int TICKS_PER_TURN = brb_pkg::TICKS_PER_TURN
);
    localparam int W_W    = $clog2(TICKS_PER_TURN / 2 + 1);
    localparam int BEAR_W = $clog2(2 * TICKS_PER_TURN) + 1;

    logic                      valid;
    logic                      ready;
    logic [W_W-1:0]            width_ticks;
    logic signed [BEAR_W-1:0]  bearing_half_ticks;
    logic [brb_pkg::DIST_W-1:0] distance_q8;
    logic                      distance_saturated;

    modport source (output valid, width_ticks, bearing_half_ticks, distance_q8,
                    distance_saturated, input ready);
    modport sink   (input valid, width_ticks, bearing_half_ticks, distance_q8,
                    distance_saturated, output ready);
endinterface

// File: sv/brb_cfg_if.sv
// Configuration write channel: one beat writes the physical beacon width.
// Depends on brb_pkg for the register width.
interface brb_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [brb_pkg::CFG_W-1:0]  beacon_width_mm;

    modport source (output valid, beacon_width_mm, input ready);
    modport sink   (input valid, beacon_width_mm, output ready);
endinterface

// File: sv/brb_cot_rom.sv
// Cotangent ROM, Q16, indexed by beacon width in ticks, with a registered read port.
// Contents are worked out at elaboration from a truncated series; depends on brb_pkg.
module brb_cot_rom #(
    parameter int TICKS_PER_TURN = brb_pkg::TICKS_PER_TURN,
    parameter int ADDR_W         = $clog2(TICKS_PER_TURN / 2 + 1),
    parameter int COT_W          = $clog2(TICKS_PER_TURN) + 15
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [ADDR_W-1:0] i_addr,
    output logic [COT_W-1:0]  o_cot
);
    localparam int DEPTH = TICKS_PER_TURN / 2 + 1;

    logic [COT_W-1:0] rom_data [DEPTH];
    logic [COT_W-1:0] r_cot;

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_entry
        localparam brb_pkg::t_u64 W_U  = brb_pkg::t_u64'(gi);
        localparam brb_pkg::t_u64 T_U  = brb_pkg::t_u64'(TICKS_PER_TURN);
        localparam brb_pkg::t_u64 X    = (brb_pkg::PI_Q30 * W_U
                                          + brb_pkg::t_u64'(TICKS_PER_TURN / 2))
                                         / TICKS_PER_TURN;
        localparam brb_pkg::t_u64 X2   = (X * X) >> brb_pkg::ANGLE_FRAC;

        // cosine series terms
        localparam brb_pkg::t_u64 TC1  = ((brb_pkg::ONE_Q30 * X2) >> 30) / 2;
        localparam brb_pkg::t_u64 TC2  = ((TC1  * X2) >> 30) / 12;
        localparam brb_pkg::t_u64 TC3  = ((TC2  * X2) >> 30) / 30;
        localparam brb_pkg::t_u64 TC4  = ((TC3  * X2) >> 30) / 56;
        localparam brb_pkg::t_u64 TC5  = ((TC4  * X2) >> 30) / 90;
        localparam brb_pkg::t_u64 TC6  = ((TC5  * X2) >> 30) / 132;
        localparam brb_pkg::t_u64 TC7  = ((TC6  * X2) >> 30) / 182;
        localparam brb_pkg::t_u64 TC8  = ((TC7  * X2) >> 30) / 240;
        localparam brb_pkg::t_u64 TC9  = ((TC8  * X2) >> 30) / 306;
        localparam brb_pkg::t_u64 TC10 = ((TC9  * X2) >> 30) / 380;
        localparam brb_pkg::t_u64 TC11 = ((TC10 * X2) >> 30) / 462;
        localparam brb_pkg::t_u64 TC12 = ((TC11 * X2) >> 30) / 552;

        // sin(x)/x series terms
        localparam brb_pkg::t_u64 TS1  = ((brb_pkg::ONE_Q30 * X2) >> 30) / 6;
        localparam brb_pkg::t_u64 TS2  = ((TS1  * X2) >> 30) / 20;
        localparam brb_pkg::t_u64 TS3  = ((TS2  * X2) >> 30) / 42;
        localparam brb_pkg::t_u64 TS4  = ((TS3  * X2) >> 30) / 72;
        localparam brb_pkg::t_u64 TS5  = ((TS4  * X2) >> 30) / 110;
        localparam brb_pkg::t_u64 TS6  = ((TS5  * X2) >> 30) / 156;
        localparam brb_pkg::t_u64 TS7  = ((TS6  * X2) >> 30) / 210;
        localparam brb_pkg::t_u64 TS8  = ((TS7  * X2) >> 30) / 272;
        localparam brb_pkg::t_u64 TS9  = ((TS8  * X2) >> 30) / 342;
        localparam brb_pkg::t_u64 TS10 = ((TS9  * X2) >> 30) / 420;
        localparam brb_pkg::t_u64 TS11 = ((TS10 * X2) >> 30) / 506;
        localparam brb_pkg::t_u64 TS12 = ((TS11 * X2) >> 30) / 600;

        localparam brb_pkg::t_s64 C_SUM = brb_pkg::t_s64'(brb_pkg::ONE_Q30)
            - brb_pkg::t_s64'(TC1)  + brb_pkg::t_s64'(TC2)
            - brb_pkg::t_s64'(TC3)  + brb_pkg::t_s64'(TC4)
            - brb_pkg::t_s64'(TC5)  + brb_pkg::t_s64'(TC6)
            - brb_pkg::t_s64'(TC7)  + brb_pkg::t_s64'(TC8)
            - brb_pkg::t_s64'(TC9)  + brb_pkg::t_s64'(TC10)
            - brb_pkg::t_s64'(TC11) + brb_pkg::t_s64'(TC12);
        localparam brb_pkg::t_s64 S_SUM = brb_pkg::t_s64'(brb_pkg::ONE_Q30)
            - brb_pkg::t_s64'(TS1)  + brb_pkg::t_s64'(TS2)
            - brb_pkg::t_s64'(TS3)  + brb_pkg::t_s64'(TS4)
            - brb_pkg::t_s64'(TS5)  + brb_pkg::t_s64'(TS6)
            - brb_pkg::t_s64'(TS7)  + brb_pkg::t_s64'(TS8)
            - brb_pkg::t_s64'(TS9)  + brb_pkg::t_s64'(TS10)
            - brb_pkg::t_s64'(TS11) + brb_pkg::t_s64'(TS12);

        // negative cosine counts as zero; guard the divisors
        localparam brb_pkg::t_u64 C_POS = (C_SUM < 0) ? 64'd0 : brb_pkg::t_u64'(C_SUM);
        localparam brb_pkg::t_u64 S_DIV = (S_SUM > 0) ? brb_pkg::t_u64'(S_SUM) : 64'd1;
        localparam brb_pkg::t_u64 R     = (C_POS << brb_pkg::ANGLE_FRAC) / S_DIV;
        localparam brb_pkg::t_u64 D     = brb_pkg::PI_Q30 * W_U;
        localparam brb_pkg::t_u64 D_DIV = (D == 64'd0) ? 64'd1 : D;
        localparam brb_pkg::t_u64 NUM   = ((R * T_U) << brb_pkg::COT_FRAC) + (D >> 1);
        localparam brb_pkg::t_u64 COT   = (S_SUM <= 0 || D == 64'd0) ? 64'd0
                                                                   : NUM / D_DIV;

        assign rom_data[gi] = COT[COT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cot <= rom_data[i_addr];
        end
    end

    assign o_cot = r_cot;
endmodule

// File: sv/beacon_range_and_bearing.sv
// Top level: beacon width, centre bearing and distance from edge tick positions.
// Depends on brb_pkg, brb_tick_if, brb_range_if, brb_cfg_if and brb_cot_rom.
//
//  Channel  | Dir | Beat payload                                       | Notes
//  ---------+-----+----------------------------------------------------+-------------------
//  i_cfg    | in  | beacon_width_mm                                    | ready out of reset
//  i_tick   | in  | rising_tick, falling_tick                          | one pair per beat
//  o_range  | out | width_ticks, bearing_half_ticks, distance_q8,      | one beat per input
//           |     | distance_saturated                                 |
//
// One beat in per cycle, one beat out per cycle while o_range is not held off; each
// accepted beat passes through three register stages in order: input register, cotangent
// ROM read register, result register.
// The distance comes from the registered ROM read and a single multiply of half the beacon width by the cotangent.
// Reset clears the stage valid bits and loads a beacon width of 60 mm.
// Stalls collapse bubbles: i_tick.ready drops only when all three stages are full and
// o_range is held off.
module beacon_range_and_bearing #(
    parameter int TICKS_PER_TURN = brb_pkg::TICKS_PER_TURN
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    brb_cfg_if.sink       i_cfg,
    brb_tick_if.sink      i_tick,
    brb_range_if.source   o_range
);
    localparam int TICK_W  = $clog2(TICKS_PER_TURN);
    localparam int W_W     = $clog2(TICKS_PER_TURN / 2 + 1);
    localparam int BEAR_W  = $clog2(2 * TICKS_PER_TURN) + 1;
    localparam int ARITH_W = TICK_W + 3;
    localparam int COT_W   = TICK_W + 15;
    localparam int HALF_W  = brb_pkg::CFG_W - 1;
    localparam int PROD_W  = HALF_W + COT_W;

    localparam logic [TICK_W-1:0]         LAST_TICK = TICK_W'(TICKS_PER_TURN - 1);
    localparam logic signed [ARITH_W-1:0] TURN_S    = ARITH_W'(TICKS_PER_TURN);
    localparam logic [W_W-1:0]            HALF_TURN = W_W'(TICKS_PER_TURN / 2);
    localparam logic [PROD_W:0]           ROUND_ADD = (PROD_W + 1)'(1 << (brb_pkg::DIST_FRAC - 1));

    // -------------------------------------------------------------------------
    // Configuration: the one register, written whenever a beat arrives
    // -------------------------------------------------------------------------
    logic [brb_pkg::CFG_W-1:0] r_beacon_width_mm;

    assign i_cfg.ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beacon_width_mm <= brb_pkg::BEACON_WIDTH_RESET;
        end else if (i_cfg.valid) begin
            r_beacon_width_mm <= i_cfg.beacon_width_mm;
        end
    end

    // -------------------------------------------------------------------------
    // Pipeline flow control: a stage loads when empty or when it is draining
    // -------------------------------------------------------------------------
    logic r_v1, r_v2, r_v3;
    logic en1, en2, en3;

    assign en3 = !r_v3 || o_range.ready;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign i_tick.ready = en1 && i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_tick.valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // -------------------------------------------------------------------------
    // Stage 1: clamp the edges into the turn and hold them
    // -------------------------------------------------------------------------
    logic [TICK_W-1:0] n_rise, n_fall;
    logic [TICK_W-1:0] r_rise, r_fall;

    assign n_rise = (i_tick.rising_tick  > LAST_TICK) ? LAST_TICK : i_tick.rising_tick;
    assign n_fall = (i_tick.falling_tick > LAST_TICK) ? LAST_TICK : i_tick.falling_tick;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_rise <= n_rise;
            r_fall <= n_fall;
        end
    end

    // -------------------------------------------------------------------------
    // Stage 1 -> 2: width folded to half a turn, bearing of the centre
    // -------------------------------------------------------------------------
    logic signed [ARITH_W-1:0] s_rise, s_fall, s_diff, s_wrap, s_width, s_bear;

    always_comb begin
        s_rise  = signed'(ARITH_W'(r_rise));
        s_fall  = signed'(ARITH_W'(r_fall));
        s_diff  = s_fall - s_rise;
        s_wrap  = (s_diff < 0) ? s_diff + TURN_S : s_diff;
        s_width = ((s_wrap <<< 1) > TURN_S) ? TURN_S - s_wrap : s_wrap;
        // Four cases: edge order, and whether the gap spans more than half a turn
        priority if (s_diff > 0) begin
            s_bear = ((s_diff <<< 1) > TURN_S) ? (s_rise <<< 1) - s_width
                                               : (s_rise <<< 1) + s_width;
        end else begin
            s_bear = ((s_diff <<< 1) < -TURN_S) ? (s_fall <<< 1) - s_width
                                                : (s_fall <<< 1) + s_width;
        end
    end

    logic [W_W-1:0]           r_width2;
    logic signed [BEAR_W-1:0] r_bear2;
    logic [COT_W-1:0]         rom_cot;

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_width2 <= s_width[W_W-1:0];
            r_bear2  <= s_bear[BEAR_W-1:0];
        end
    end

    // Cotangent read lands alongside r_width2
    brb_cot_rom #(
        .TICKS_PER_TURN (TICKS_PER_TURN),
        .ADDR_W         (W_W),
        .COT_W          (COT_W)
    ) u_cot_rom (
        .i_clk  (i_clk),
        .i_en   (en2),
        .i_addr (s_width[W_W-1:0]),
        .o_cot  (rom_cot)
    );

    // -------------------------------------------------------------------------
    // Stage 2 -> 3: scale by half the beacon width, round off the Q16 to Q8, saturate
    // -------------------------------------------------------------------------
    logic [HALF_W-1:0]              half_mm;
    logic [PROD_W-1:0]              s_prod;
    logic [PROD_W:0]                s_sum;
    logic [PROD_W-brb_pkg::DIST_FRAC:0] s_round;
    logic                           s_zero, s_over;
    logic [brb_pkg::DIST_W-1:0]     n_distance;
    logic                           n_sat;

    always_comb begin
        half_mm    = r_beacon_width_mm[brb_pkg::CFG_W-1:1];
        s_prod     = PROD_W'(half_mm) * PROD_W'(rom_cot);
        s_sum      = (PROD_W + 1)'(s_prod) + ROUND_ADD;
        s_round    = s_sum[PROD_W:brb_pkg::DIST_FRAC];
        s_zero     = (r_width2 == '0);
        s_over     = brb_pkg::t_u64'(s_round) > brb_pkg::t_u64'(brb_pkg::DIST_MAX);
        n_sat      = s_zero || s_over;
        n_distance = n_sat ? brb_pkg::DIST_MAX : s_round[brb_pkg::DIST_W-1:0];
    end

    logic [W_W-1:0]              r_width3;
    logic signed [BEAR_W-1:0]    r_bear3;
    logic [brb_pkg::DIST_W-1:0]  r_distance3;
    logic                        r_sat3;

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_width3    <= r_width2;
            r_bear3     <= r_bear2;
            r_distance3 <= n_distance;
            r_sat3      <= n_sat;
        end
    end

    assign o_range.valid              = r_v3;
    assign o_range.width_ticks        = r_width3;
    assign o_range.bearing_half_ticks = r_bear3;
    assign o_range.distance_q8        = r_distance3;
    assign o_range.distance_saturated = r_sat3;

    // -------------------------------------------------------------------------
    // Checks
    // -------------------------------------------------------------------------
    a_width_folded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> r_width3 <= HALF_TURN)
        else $error("width beyond half a turn");

    a_zero_width_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && r_width3 == '0 |-> r_sat3 && r_distance3 == brb_pkg::DIST_MAX)
        else $error("zero width not saturated");

    a_sat_is_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && r_sat3 |-> r_distance3 == brb_pkg::DIST_MAX)
        else $error("saturated beat without full-scale distance");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && r_v2 && r_v3 && !o_range.ready |-> !i_tick.ready)
        else $error("input taken while pipeline full and stalled");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && !en3 |=> r_v2 && $stable(r_width2) && $stable(r_bear2))
        else $error("middle stage lost its beat under stall");
endmodule
